@@ hw/rtl/assert_macros.svh @@
// Assertion helpers, included by line_sensor_position_core.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LSP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define LSP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ hw/rtl/lsp_pkg.sv @@
`timescale 1ns / 1ps
package lsp_pkg;

	localparam int NUM_SENSORS_DEF = 8;
	localparam int SAMPLE_BITS_DEF = 10;

	localparam int SAMPLE_W = 10;   // port width of one raw sample
	localparam int CFG_W    = 10;   // width of both config registers
	localparam int PAT_W    = 8;    // on/off pattern width
	localparam int CNT_W    = 4;    // on-sensor count width
	localparam int POS_W    = 16;   // line position width
	localparam int SIDE_W   = 2;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [CFG_W-1:0] ON_THRESHOLD_RST   = CFG_W'(50);
	localparam logic [CFG_W-1:0] POSITION_SCALE_RST = CFG_W'(1000);

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_ON_THRESHOLD   = 1'b0,
		REG_POSITION_SCALE = 1'b1
	} lsp_reg_t;

	localparam logic signed [SIDE_W-1:0] SIDE_NONE  = 2'sb00;
	localparam logic signed [SIDE_W-1:0] SIDE_LEFT  = 2'sb11;
	localparam logic signed [SIDE_W-1:0] SIDE_RIGHT = 2'sb01;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_DSTART,
		ST_DIV
	} lsp_state_t;

	// per-lane threshold compare result
	typedef struct packed {
		logic gt;   // calibrated value above threshold
		logic lt;   // calibrated value below threshold
	} lsp_flag_t;

	// merged per-word status
	typedef struct packed {
		logic                     no_weight;
		logic                     match;
		logic signed [SIDE_W-1:0] side;
		logic [CNT_W-1:0]         count;
		logic [PAT_W-1:0]         pattern;
	} lsp_merge_t;

endpackage

@@ hw/rtl/line_sensor_position_core.sv @@
`timescale 1ns / 1ps
// Channel  | handshake                   | word
// ---------+-----------------------------+--------------------------------------------
// input    | in_valid / in_ready         | req_type, sample_0..7, pattern_compare/mask
// output   | out_valid / out_ready       | line_position, no_weight, on_count,
//          |                             | on_pattern, pattern_match, last_side
// config   | psel/penable/pwrite, pready | paddr, pwdata, prdata
//
// One word at a time: accept, lane multiply, merge sum, divider load, then
// SW quotient bits (SW = SAMPLE_BITS + 2*clog2(NUM_SENSORS) + 12, 28 by default)
// from the shared restoring divider, then the output register load.
// The result sits in an output register; the next word is taken while it waits.
// arst_n sets the FSM, config defaults, per-sensor minimums (all ones) and side.
// A stalled output holds the divider result until the output register frees up.
`include "assert_macros.svh"
module line_sensor_position_core import lsp_pkg::*; #(
	parameter int NUM_SENSORS = NUM_SENSORS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input words
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     req_type,
	input  logic [SAMPLE_W-1:0]      sample_0,
	input  logic [SAMPLE_W-1:0]      sample_1,
	input  logic [SAMPLE_W-1:0]      sample_2,
	input  logic [SAMPLE_W-1:0]      sample_3,
	input  logic [SAMPLE_W-1:0]      sample_4,
	input  logic [SAMPLE_W-1:0]      sample_5,
	input  logic [SAMPLE_W-1:0]      sample_6,
	input  logic [SAMPLE_W-1:0]      sample_7,
	input  logic [PAT_W-1:0]         pattern_compare,
	input  logic [PAT_W-1:0]         pattern_mask,
	// result words
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [POS_W-1:0]  line_position,
	output logic                     no_weight,
	output logic [CNT_W-1:0]         on_count,
	output logic [PAT_W-1:0]         on_pattern,
	output logic                     pattern_match,
	output logic signed [SIDE_W-1:0] last_side,
	// config
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready
);

	localparam int VW   = SAMPLE_BITS + 1;
	localparam int IDXW = $clog2(NUM_SENSORS);
	localparam int WW   = IDXW + CFG_W;
	localparam int PW   = VW + WW + 1;
	localparam int SW   = PW + IDXW;
	localparam int TW   = VW + IDXW;

	// ---------------- config registers ----------------
	logic [CFG_W-1:0] on_threshold_q;
	logic [CFG_W-1:0] position_scale_q;
	lsp_reg_t         reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = lsp_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_threshold_q   <= ON_THRESHOLD_RST;
			position_scale_q <= POSITION_SCALE_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_ON_THRESHOLD:   on_threshold_q   <= pwdata[CFG_W-1:0];
				REG_POSITION_SCALE: position_scale_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_ON_THRESHOLD:   prdata = DATA_W'(on_threshold_q);
			REG_POSITION_SCALE: prdata = DATA_W'(position_scale_q);
			default:            prdata = '0;
		endcase
	end

	// ---------------- sequencer ----------------
	lsp_state_t state_q;
	lsp_state_t state_d;
	logic       accept;
	logic       sum_en;
	logic       div_start;
	logic       div_busy;
	logic       out_load;
	logic       out_valid_q;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		sum_en    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_SUM;
			end
			ST_SUM: begin
				sum_en  = 1'b1;
				state_d = ST_DSTART;
			end
			ST_DSTART: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				// wait for the quotient and a free output register
				if (!div_busy && (!out_valid_q || out_ready)) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- sensor lanes ----------------
	logic [SAMPLE_W-1:0]   smp  [8];
	logic signed [PW-1:0]  prod [NUM_SENSORS];
	logic signed [VW-1:0]  vval [NUM_SENSORS];
	lsp_flag_t             flag [NUM_SENSORS];

	assign smp[0] = sample_0;
	assign smp[1] = sample_1;
	assign smp[2] = sample_2;
	assign smp[3] = sample_3;
	assign smp[4] = sample_4;
	assign smp[5] = sample_5;
	assign smp[6] = sample_6;
	assign smp[7] = sample_7;

	for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
		lsp_lane #(
			.NUM_SENSORS (NUM_SENSORS),
			.SAMPLE_BITS (SAMPLE_BITS),
			.LANE_IDX    (g)
		) u_lane (
			.clk            (clk),
			.arst_n         (arst_n),
			.load           (accept),
			.cal            (req_type),
			.sample         (smp[g]),
			.on_threshold   (on_threshold_q),
			.position_scale (position_scale_q),
			.v_s1           (vval[g]),
			.prod_s2        (prod[g]),
			.flag_s2        (flag[g])
		);
	end

	// compare/mask travel with the word
	logic [PAT_W-1:0] cmp_s1;
	logic [PAT_W-1:0] msk_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmp_s1 <= pattern_compare;
			msk_s1 <= pattern_mask;
		end
	end

	// ---------------- merge ----------------
	logic signed [SW-1:0] wsum_s3;
	logic signed [TW-1:0] wtot_s3;
	lsp_merge_t           res_s3;

	lsp_merge #(
		.NUM_SENSORS (NUM_SENSORS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_merge (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (sum_en),
		.prod            (prod),
		.v               (vval),
		.flag            (flag),
		.pattern_compare (cmp_s1),
		.pattern_mask    (msk_s1),
		.wsum_s3         (wsum_s3),
		.wtot_s3         (wtot_s3),
		.res_s3          (res_s3)
	);

	// ---------------- divider ----------------
	logic signed [POS_W-1:0] quo;

	lsp_div #(
		.NW (SW),
		.DW (TW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (wsum_s3),
		.den    (wtot_s3),
		.busy   (div_busy),
		.quo    (quo)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			line_position <= res_s3.no_weight ? '0 : quo;
			no_weight     <= res_s3.no_weight;
			on_count      <= res_s3.count;
			on_pattern    <= res_s3.pattern;
			pattern_match <= res_s3.match;
			last_side     <= res_s3.side;
		end
	end

	assign out_valid = out_valid_q;

	// ---------------- checks ----------------
	`LSP_ASSERT(a_zero_pos, clk, arst_n, out_valid && no_weight |-> line_position == '0, "position must be zero without weight")
	`LSP_ASSERT(a_count, clk, arst_n, out_valid |-> $countones(on_pattern) == 32'(on_count), "count disagrees with pattern")
	`LSP_ASSERT_NEVER(a_side, clk, arst_n, out_valid && last_side == 2'sb10, "illegal side code")
	`LSP_ASSERT_NEVER(a_acc_busy, clk, arst_n, accept && div_busy, "word accepted during divide")

endmodule

@@ hw/rtl/lsp_lane.sv @@
`timescale 1ns / 1ps
module lsp_lane import lsp_pkg::*; #(
	parameter int NUM_SENSORS = NUM_SENSORS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int LANE_IDX    = 0,
	localparam int VW   = SAMPLE_BITS + 1,
	localparam int IDXW = $clog2(NUM_SENSORS),
	localparam int WW   = IDXW + CFG_W,
	localparam int PW   = VW + WW + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic                   cal,
	input  logic [SAMPLE_W-1:0]    sample,
	input  logic [CFG_W-1:0]       on_threshold,
	input  logic [CFG_W-1:0]       position_scale,
	output logic signed [VW-1:0]   v_s1,
	output logic signed [PW-1:0]   prod_s2,
	output lsp_flag_t              flag_s2
);

	localparam int CMPW = (VW > CFG_W + 1) ? VW : CFG_W + 1;

	logic [SAMPLE_BITS-1:0] smp;
	logic [SAMPLE_BITS-1:0] cal_q;
	logic [SAMPLE_BITS-1:0] cal_n;
	logic signed [VW-1:0]   v_d;
	logic [WW-1:0]          w_q;
	logic signed [CMPW-1:0] v_c;
	logic signed [CMPW-1:0] th_c;

	assign smp   = SAMPLE_BITS'(sample);
	assign cal_n = (cal && (smp < cal_q)) ? smp : cal_q;
	assign v_d   = $signed({1'b0, smp}) - $signed({1'b0, cal_n});

	// minimum tracker, all ones until calibrated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '1;
		end else if (load) begin
			cal_q <= cal_n;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			v_s1 <= v_d;
		end
	end

	// index weight follows the scale register
	always_ff @(posedge clk) begin
		w_q <= WW'(LANE_IDX) * WW'(position_scale);
	end

	assign v_c  = CMPW'(v_s1);
	assign th_c = CMPW'($signed({1'b0, on_threshold}));

	always_ff @(posedge clk) begin
		prod_s2    <= PW'(v_s1) * PW'($signed({1'b0, w_q}));
		flag_s2.gt <= v_c > th_c;
		flag_s2.lt <= v_c < th_c;
	end

endmodule

@@ hw/rtl/lsp_merge.sv @@
`timescale 1ns / 1ps
module lsp_merge import lsp_pkg::*; #(
	parameter int NUM_SENSORS = NUM_SENSORS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int VW   = SAMPLE_BITS + 1,
	localparam int IDXW = $clog2(NUM_SENSORS),
	localparam int WW   = IDXW + CFG_W,
	localparam int PW   = VW + WW + 1,
	localparam int SW   = PW + IDXW,
	localparam int TW   = VW + IDXW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic signed [PW-1:0]  prod [NUM_SENSORS],
	input  logic signed [VW-1:0]  v    [NUM_SENSORS],
	input  lsp_flag_t             flag [NUM_SENSORS],
	input  logic [PAT_W-1:0]      pattern_compare,
	input  logic [PAT_W-1:0]      pattern_mask,
	output logic signed [SW-1:0]  wsum_s3,
	output logic signed [TW-1:0]  wtot_s3,
	output lsp_merge_t            res_s3
);

	logic signed [SW-1:0]     wsum_d;
	logic signed [TW-1:0]     wtot_d;
	logic [PAT_W-1:0]         pat_d;
	logic [CNT_W-1:0]         cnt_d;
	logic signed [SIDE_W-1:0] side_q;
	logic signed [SIDE_W-1:0] side_d;

	always_comb begin
		wsum_d = '0;
		wtot_d = '0;
		pat_d  = '0;
		cnt_d  = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			wsum_d   = wsum_d + SW'(prod[i]);
			wtot_d   = wtot_d + TW'(v[i]);
			pat_d[i] = flag[i].gt;
			cnt_d    = cnt_d + CNT_W'(flag[i].gt);
		end
	end

	// equality on either end leaves the side unchanged
	always_comb begin
		priority if (flag[0].gt && flag[NUM_SENSORS-1].lt) begin
			side_d = SIDE_LEFT;
		end else if (flag[0].lt && flag[NUM_SENSORS-1].gt) begin
			side_d = SIDE_RIGHT;
		end else begin
			side_d = side_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_NONE;
		end else if (en) begin
			side_q <= side_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wsum_s3           <= wsum_d;
			wtot_s3           <= wtot_d;
			res_s3.no_weight  <= (wtot_d == '0);
			res_s3.match      <= (pat_d & pattern_mask) == (pattern_compare & pattern_mask);
			res_s3.side       <= side_d;
			res_s3.count      <= cnt_d;
			res_s3.pattern    <= pat_d;
		end
	end

endmodule

@@ hw/rtl/lsp_div.sv @@
`timescale 1ns / 1ps
module lsp_div import lsp_pkg::*; #(
	parameter int NW = 28,
	parameter int DW = 14
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NW-1:0]    num,
	input  logic signed [DW-1:0]    den,
	output logic                    busy,
	output logic signed [POS_W-1:0] quo
);

	localparam int CW = $clog2(NW + 1);
	localparam logic [NW-1:0] POS_MAX = NW'((1 << (POS_W - 1)) - 1);
	localparam logic [NW-1:0] NEG_MAX = NW'(1 << (POS_W - 1));

	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic          neg_q;
	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_sub;
	logic [NW-1:0] num_mag;
	logic [DW-1:0] den_mag;

	assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);
	assign den_mag = den[DW-1] ? DW'(-den) : DW'(den);
	assign rem_sh  = {rem_q, quo_q[NW-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign busy    = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// restoring division on magnitudes, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num_mag;
			den_q <= den_mag;
			rem_q <= '0;
			neg_q <= num[NW-1] ^ den[DW-1];
		end else if (busy) begin
			if (!rem_sub[DW]) begin
				rem_q <= rem_sub[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	// sign and saturate
	always_comb begin
		if (neg_q) begin
			quo = (quo_q > NEG_MAX) ? $signed(POS_W'(NEG_MAX)) : $signed(POS_W'(NW'(-quo_q)));
		end else begin
			quo = (quo_q > POS_MAX) ? $signed(POS_W'(POS_MAX)) : $signed(POS_W'(quo_q));
		end
	end

endmodule

@@ test/line_sensor_position_core_test.sv @@
`timescale 1ns / 1ps
module line_sensor_position_core_test;
	import lsp_pkg::*;

	// one input word: request bit, eight samples (index 0 = leftmost), compare/mask
	typedef struct packed {
		logic                      req;
		logic [7:0][SAMPLE_W-1:0]  smp;
		logic [PAT_W-1:0]          cmp;
		logic [PAT_W-1:0]          msk;
	} snapshot_t;

	// one result word, raw bits as they appear on the ports
	typedef struct packed {
		logic [POS_W-1:0]  position;
		logic              no_wt;
		logic [CNT_W-1:0]  count;
		logic [PAT_W-1:0]  pattern;
		logic              matched;
		logic [SIDE_W-1:0] side;
	} reading_t;

	typedef struct {
		snapshot_t w;
		bit        typed;   // result written out by hand below
		reading_t  want;
	} plan_row_t;

	localparam int QUIET_LIMIT = 3000;   // cycles with no handshake at all
	localparam int DRAIN_WAIT  = 40;     // a bit more than one word's trip through the divider
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 180;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	snapshot_t                drive_word = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [POS_W-1:0]  line_position;
	logic                     no_weight;
	logic [CNT_W-1:0]         on_count;
	logic [PAT_W-1:0]         on_pattern;
	logic                     pattern_match;
	logic signed [SIDE_W-1:0] last_side;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [ADDR_W-1:0]        paddr = '0;
	logic [DATA_W-1:0]        pwdata = '0;
	logic [DATA_W-1:0]        prdata;
	logic                     pready;

	// mirror of the block: per-sensor minimums, side memory, both registers
	logic [SAMPLE_W-1:0]      cal_min [8];
	logic [SIDE_W-1:0]        side_mem;
	logic [CFG_W-1:0]         thr_cfg;
	logic [CFG_W-1:0]         scale_cfg;

	reading_t                 expected_readings [$];
	plan_row_t                plan [$];
	int                       gap_pct = 0;     // sender idle chance per cycle
	int                       stall_pct = 0;   // receiver stall chance per cycle
	int                       errors = 0;
	int                       results_seen = 0;
	int                       quiet_cycles = 0;

	always #10 clk = ~clk;

	line_sensor_position_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (drive_word.req),
		.sample_0        (drive_word.smp[0]),
		.sample_1        (drive_word.smp[1]),
		.sample_2        (drive_word.smp[2]),
		.sample_3        (drive_word.smp[3]),
		.sample_4        (drive_word.smp[4]),
		.sample_5        (drive_word.smp[5]),
		.sample_6        (drive_word.smp[6]),
		.sample_7        (drive_word.smp[7]),
		.pattern_compare (drive_word.cmp),
		.pattern_mask    (drive_word.msk),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.line_position   (line_position),
		.no_weight       (no_weight),
		.on_count        (on_count),
		.on_pattern      (on_pattern),
		.pattern_match   (pattern_match),
		.last_side       (last_side),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	function automatic logic [SAMPLE_W-1:0] clip10(input int x);
		if (x < 0)
			return '0;
		if (x > 1023)
			return 10'd1023;
		return SAMPLE_W'(x);
	endfunction

	// sensor 0 first, as the samples read left to right
	function automatic logic [7:0][SAMPLE_W-1:0] lanes(input int a0, a1, a2, a3,
			a4, a5, a6, a7);
		return {clip10(a7), clip10(a6), clip10(a5), clip10(a4),
			clip10(a3), clip10(a2), clip10(a1), clip10(a0)};
	endfunction

	// Predicts one result word and advances the mirrored state.
	// Minimums drop first on a calibrate word; v = sample - minimum may go negative.
	task automatic track_line(input snapshot_t w, output reading_t r);
		int     v [8];
		int     th;
		longint wsum;
		longint wtot;
		longint q;
		int     i;
		th = int'(thr_cfg);
		wsum = 0;
		wtot = 0;
		r = '0;
		for (i = 0; i < 8; i++) begin
			if (w.req && w.smp[i] < cal_min[i])
				cal_min[i] = w.smp[i];
			v[i] = int'(w.smp[i]) - int'(cal_min[i]);
			if (v[i] > th) begin
				r.pattern[i] = 1'b1;
				r.count = r.count + 1'b1;
			end
			wtot += v[i];
			wsum += longint'(v[i]) * longint'(i) * longint'(scale_cfg);
		end
		// edge sensors on exactly at the threshold count as neither side
		if (v[0] > th && v[7] < th)
			side_mem = SIDE_LEFT;
		else if (v[0] < th && v[7] > th)
			side_mem = SIDE_RIGHT;
		if (wtot == 0) begin
			r.no_wt = 1'b1;
			q = 0;
		end else begin
			q = wsum / wtot;   // truncates toward zero, also for a negative weight sum
			if (q > 32767)
				q = 32767;
			else if (q < -32768)
				q = -32768;
		end
		r.position = q[POS_W-1:0];
		r.matched = ((r.pattern & w.msk) == (w.cmp & w.msk));
		r.side = side_mem;
	endtask

	task automatic add_row(input logic req, input logic [7:0][SAMPLE_W-1:0] smp,
			input logic [PAT_W-1:0] cmp, input logic [PAT_W-1:0] msk,
			input bit typed, input reading_t want);
		plan_row_t row;
		row.w = '{req, smp, cmp, msk};
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endtask

	// Random word, shaped around the current minimums so most words look like a
	// line on a calibrated floor; the rest are zero-sum, uniform and extreme words.
	function automatic snapshot_t random_word();
		snapshot_t w;
		int        kind;
		int        c;
		int        wd;
		int        acc;
		int        i;
		kind = $urandom_range(99);
		w.req = 1'b0;
		w.cmp = 8'($urandom);
		w.msk = $urandom_range(1) ? 8'($urandom) : 8'($urandom & $urandom);
		if (kind < 55) begin
			w.req = ($urandom_range(99) < 15);
			for (i = 0; i < 8; i++)
				w.smp[i] = w.req ? clip10($urandom_range(20, 300))
					: clip10(int'(cal_min[i]) + int'($urandom_range(70)) - 30);
			c = $urandom_range(7);
			wd = $urandom_range(1, 3);
			for (i = c; i < c + wd && i < 8; i++)
				w.smp[i] = clip10(int'(cal_min[i]) + int'($urandom_range(40, 1023)));
		end else if (kind < 70) begin
			// weight sum lands on zero or within two of it: no_weight and saturation
			acc = 0;
			for (i = 0; i < 7; i++) begin
				w.smp[i] = clip10(int'(cal_min[i]) + int'($urandom_range(200)) - 100);
				acc += int'(w.smp[i]) - int'(cal_min[i]);
			end
			w.smp[7] = clip10(int'(cal_min[7]) - acc + int'($urandom_range(4)) - 2);
		end else if (kind < 85) begin
			for (i = 0; i < 8; i++)
				w.smp[i] = SAMPLE_W'($urandom_range(1023));
		end else begin
			for (i = 0; i < 8; i++)
				w.smp[i] = $urandom_range(1) ? 10'd1023 : 10'd0;
		end
		return w;
	endfunction

	// Waits out a random gap, then holds the word until in_ready takes it.
	task automatic send_word(input snapshot_t w, input bit typed, input reading_t typed_want);
		reading_t want;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < gap_pct);
		end
		drive_word <= w;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		track_line(w, want);
		expected_readings.push_back(typed ? typed_want : want);
	endtask

	// Setup cycle, then access cycle; upper data bits carry junk the block must drop.
	task automatic apb_write(input lsp_reg_t idx, input logic [CFG_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {22'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ON_THRESHOLD: thr_cfg = val;
			REG_POSITION_SCALE: scale_cfg = val;
		endcase
		@(posedge clk);
	endtask

	// block idle: nothing in flight, divider done
	task automatic quiesce();
		in_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic note_mismatch(input string field, input longint want, input longint got);
		errors++;
		if (errors <= 100)
			$display("%0d ns: word %0d %s expected %0d got %0d", $time, results_seen,
				field, want, got);
	endtask

	// receiver: random stalls, every accepted word checked against the oldest prediction
	always @(posedge clk) begin
		reading_t got;
		reading_t want;
		out_ready <= ($urandom_range(99) >= stall_pct);
		if (arst_n && out_valid && out_ready) begin
			got = '{line_position, no_weight, on_count, on_pattern, pattern_match, last_side};
			if (expected_readings.size() == 0) begin
				note_mismatch("unexpected word, line_position", 0, $signed(got.position));
			end else begin
				want = expected_readings.pop_front();
				if (got.position !== want.position)
					note_mismatch("line_position", $signed(want.position),
						$signed(got.position));
				if (got.no_wt !== want.no_wt)
					note_mismatch("no_weight", want.no_wt, got.no_wt);
				if (got.count !== want.count)
					note_mismatch("on_count", want.count, got.count);
				if (got.pattern !== want.pattern)
					note_mismatch("on_pattern", want.pattern, got.pattern);
				if (got.matched !== want.matched)
					note_mismatch("pattern_match", want.matched, got.matched);
				if (got.side !== want.side)
					note_mismatch("last_side", $signed(want.side), $signed(got.side));
			end
			results_seen++;
		end
	end

	// watchdog on any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("line_sensor_position_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		int p;
		int thr;
		int sc;
		for (p = 0; p < 8; p++)
			cal_min[p] = 10'h3FF;
		side_mem = SIDE_NONE;
		thr_cfg = ON_THRESHOLD_RST;
		scale_cfg = POSITION_SCALE_RST;

		// Directed words, reset config (threshold 50, scale 1000).
		//       req   samples, sensor 0 first                            cmp    msk
		// nothing calibrated yet: all-ones samples give zero weight
		add_row(1'b0, lanes(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023), 8'h00, 8'h00,
			1'b1, '{16'd0, 1'b1, 4'd0, 8'h00, 1'b1, SIDE_NONE});
		// every v at -1023: negative sum, centroid 3.5 sensors
		add_row(1'b0, lanes(0, 0, 0, 0, 0, 0, 0, 0), 8'hFF, 8'hFF,
			1'b1, '{16'd3500, 1'b0, 4'd0, 8'h00, 1'b0, SIDE_NONE});
		add_row(1'b0, lanes(1000, 900, 800, 700, 600, 500, 400, 300), 8'h3C, 8'h5A,
			1'b0, '0);
		// calibrate to a flat floor of 100
		add_row(1'b1, lanes(100, 100, 100, 100, 100, 100, 100, 100), 8'h00, 8'hFF,
			1'b1, '{16'd0, 1'b1, 4'd0, 8'h00, 1'b1, SIDE_NONE});
		// leftmost only: side goes left
		add_row(1'b0, lanes(1023, 100, 100, 100, 100, 100, 100, 100), 8'h01, 8'hFF,
			1'b1, '{16'd0, 1'b0, 4'd1, 8'h01, 1'b1, SIDE_LEFT});
		// rightmost only: side goes right
		add_row(1'b0, lanes(100, 100, 100, 100, 100, 100, 100, 1023), 8'h01, 8'h81,
			1'b1, '{16'd7000, 1'b0, 4'd1, 8'h80, 1'b0, SIDE_RIGHT});
		// all on, side kept
		add_row(1'b0, lanes(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023), 8'hAA, 8'h0F,
			1'b1, '{16'd3500, 1'b0, 4'd8, 8'hFF, 1'b0, SIDE_RIGHT});
		// below the floor everywhere
		add_row(1'b0, lanes(0, 0, 0, 0, 0, 0, 0, 0), 8'h00, 8'hFF,
			1'b1, '{16'd3500, 1'b0, 4'd0, 8'h00, 1'b1, SIDE_RIGHT});
		// edge sensors sitting right at the threshold
		add_row(1'b0, lanes(151, 100, 100, 100, 100, 100, 100, 150), 8'h55, 8'hFF,
			1'b0, '0);
		add_row(1'b0, lanes(150, 100, 100, 100, 100, 100, 100, 151), 8'h80, 8'hC1,
			1'b0, '0);
		// positive and negative values cancel
		add_row(1'b0, lanes(0, 200, 100, 100, 100, 100, 100, 100), 8'h02, 8'hFF,
			1'b1, '{16'd0, 1'b1, 4'd1, 8'h02, 1'b1, SIDE_RIGHT});
		// weight sum +1 and -1: position clips both ways
		add_row(1'b0, lanes(0, 100, 100, 100, 100, 100, 100, 201), 8'h00, 8'h00,
			1'b1, '{16'h7FFF, 1'b0, 4'd1, 8'h80, 1'b1, SIDE_RIGHT});
		add_row(1'b0, lanes(0, 98, 100, 100, 100, 100, 100, 201), 8'hFF, 8'h80,
			1'b1, '{16'h8000, 1'b0, 4'd1, 8'h80, 1'b1, SIDE_RIGHT});
		add_row(1'b0, lanes(400, 100, 100, 100, 100, 100, 400, 100), 8'h41, 8'hFF,
			1'b0, '0);
		// calibrate lowers only the sensors that read below their minimum
		add_row(1'b1, lanes(50, 150, 100, 20, 100, 100, 100, 1023), 8'h80, 8'h80,
			1'b0, '0);
		add_row(1'b0, lanes(1023, 0, 1023, 0, 1023, 0, 1023, 0), 8'h55, 8'hFF,
			1'b0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r])
			send_word(plan[r].w, plan[r].typed, plan[r].want);

		for (p = 0; p < PHASES; p++) begin
			quiesce();
			case (p)
				0: begin thr = 50; sc = 1000; end
				1: begin thr = 0; sc = 1023; end
				2: begin thr = 1023; sc = 1; end
				3: begin thr = $urandom_range(1023); sc = 0; end   // zero scale
				4: begin thr = $urandom_range(10, 200); sc = $urandom_range(1, 1023); end
				5: begin thr = $urandom_range(60); sc = 1023; end
				6: begin thr = 1; sc = $urandom_range(1, 1023); end
				default: begin thr = $urandom_range(300); sc = $urandom_range(1023); end
			endcase
			apb_write(REG_ON_THRESHOLD, CFG_W'(thr));
			apb_write(REG_POSITION_SCALE, CFG_W'(sc));
			// rotate: no idling, sender idle, receiver stalling, both
			case (p % 4)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 71; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 71; end
				default: begin gap_pct = 35; stall_pct = 35; end
			endcase
			repeat (PHASE_WORDS)
				send_word(random_word(), 1'b0, '0);
		end

		quiesce();
		if (errors == 0)
			$display("line_sensor_position_core verification clean");
		else
			$display("line_sensor_position_core verification failed");
		$finish;
	end

endmodule

@@ line_sensor_position_core.f @@
+incdir+hw/rtl
hw/rtl/lsp_pkg.sv
hw/rtl/lsp_lane.sv
hw/rtl/lsp_merge.sv
hw/rtl/lsp_div.sv
hw/rtl/line_sensor_position_core.sv
test/line_sensor_position_core_test.sv
